// File: rtl/laq_pkg.sv
// Shared types and constants for the linear array queue.
// Holds the operation and status codes and the default depth; depends on nothing.
package laq_pkg;

	localparam int unsigned DEPTH_DEF = 8;
	localparam int unsigned DATA_W    = 32;

	typedef enum logic [1:0] {
		FN_ENQ  = 2'd0,
		FN_DEQ  = 2'd1,
		FN_PEEK = 2'd2,
		FN_DISP = 2'd3
	} func_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

endpackage

// File: rtl/linear_array_queue_core.sv
// Top level of the linear array queue: request decode, index state, result register.
// Depends on laq_pkg and instantiates laq_ram for the slot storage.

// The queue keeps up to DEPTH signed 32-bit elements on a linear array that never
// wraps: once the tail sits on the last slot, enqueue is refused with status full
// even if slots at the front were freed; only dequeuing the last element resets both
// indices to zero. Each input request carries an operation in s_tuser (enqueue,
// dequeue, peek, display) and the element in s_tdata. Enqueue, and any operation on
// an empty queue, produce one result in the cycle after the request. Dequeue and
// peek read the front slot from the synchronous slot memory, so their one result
// passes through the memory read register and then the result register. Display
// streams every stored element from front to rear, one per cycle while the result
// register is free; m_tlast marks its final result, and every other operation
// always sets m_tlast on its single result. A new request is taken whenever the
// block is idle and the result register is empty or being drained in the same
// cycle; while a dequeue, peek or display is still delivering results, s_tready
// stays low. Slots start undefined; the indices only ever cover written slots, so
// no clearing is needed.
module linear_array_queue_core #(
	parameter int unsigned DEPTH = laq_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input requests.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [laq_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
	input  logic [1:0]                 s_tuser,   // [1:0] func
	// Results.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [laq_pkg::DATA_W-1:0] m_tdata,   // [31:0] data
	output logic [1:0]                 m_tuser,   // [1:0] status
	output logic                       m_tlast
);
	import laq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	typedef enum logic {
		S_IDLE,
		S_STREAM
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic              empty_q;
	// Read pointer and final index of the run being streamed out.
	logic [AW-1:0]     ptr_q;
	logic [AW-1:0]     end_q;

	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	status_t           m_tuser_q;
	logic              m_tlast_q;

	logic              out_free;
	logic              accept;
	logic              res_load;
	func_t             func;
	logic              enq_fits;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	// The result register is free if empty or being taken in this cycle.
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;
	assign func     = func_t'(s_tuser);

	// A result is loaded right away for enqueue or an empty queue, and once per
	// free cycle while a run is streamed out.
	assign res_load = (accept && ((func == FN_ENQ) || empty_q))
		|| ((state_q == S_STREAM) && out_free);

	// An empty queue always takes the element at slot zero; otherwise the tail
	// must not already sit on the last slot.
	assign enq_fits  = empty_q || (tail_q != LAST_IDX);
	assign ram_we    = accept && (func == FN_ENQ) && enq_fits;
	assign ram_waddr = empty_q ? '0 : tail_q + AW'(1);

	// The first read goes out with the request; later reads go out as each result
	// is loaded, so the registered read data always matches ptr_q while streaming.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = head_q;
		if (accept && (func != FN_ENQ) && !empty_q) begin
			ram_re    = 1'b1;
			ram_raddr = head_q;
		end else if ((state_q == S_STREAM) && out_free && (ptr_q != end_q)) begin
			ram_re    = 1'b1;
			ram_raddr = ptr_q + AW'(1);
		end
	end

	laq_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (s_tdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			empty_q    <= 1'b1;
			ptr_q      <= '0;
			end_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= ST_OK;
			m_tlast_q  <= 1'b0;
		end else begin
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (func == FN_ENQ) begin
							m_tdata_q  <= '0;
							m_tlast_q  <= 1'b1;
							m_tuser_q  <= enq_fits ? ST_OK : ST_FULL;
							if (empty_q) begin
								head_q  <= '0;
								tail_q  <= '0;
								empty_q <= 1'b0;
							end else if (enq_fits) begin
								tail_q <= tail_q + AW'(1);
							end
						end else if (empty_q) begin
							m_tdata_q  <= '0;
							m_tlast_q  <= 1'b1;
							m_tuser_q  <= ST_EMPTY;
						end else begin
							// Dequeue and peek stream a run of one element.
							ptr_q   <= head_q;
							end_q   <= (func == FN_DISP) ? tail_q : head_q;
							state_q <= S_STREAM;
							if (func == FN_DEQ) begin
								if (head_q == tail_q) begin
									head_q  <= '0;
									tail_q  <= '0;
									empty_q <= 1'b1;
								end else begin
									head_q <= head_q + AW'(1);
								end
							end
						end
					end
				end
				S_STREAM: begin
					if (out_free) begin
						m_tdata_q  <= ram_rdata;
						m_tuser_q  <= ST_OK;
						m_tlast_q  <= (ptr_q == end_q);
						if (ptr_q == end_q) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// A non-empty queue never has its front behind its rear.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (head_q <= tail_q))
		else $error("head index passed tail index");

	// An empty queue keeps both indices at zero.
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> ((head_q == '0) && (tail_q == '0)))
		else $error("empty queue with nonzero indices");

	// A streamed run never reads past its final index.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STREAM) |-> (ptr_q <= end_q))
		else $error("stream pointer beyond end of run");

	// Results of an empty or full status carry no element and end their request.
	a_status_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_OK)) |-> ((m_tdata == '0) && m_tlast))
		else $error("error status with element data");

	// Leaving the stream state follows the loading of a final result.
	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_STREAM) && out_free && (ptr_q == end_q))
		|=> ((state_q == S_IDLE) && m_tvalid_q && m_tlast_q))
		else $error("stream ended without final result");

endmodule

// File: rtl/laq_ram.sv
// Slot storage of the linear array queue: one write port, one read port, registered read data.
// Depends on laq_pkg for the element width.
module laq_ram #(
	parameter int unsigned DEPTH = laq_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(DEPTH)-1:0]           waddr,
	input  logic [laq_pkg::DATA_W-1:0]         wdata,
	input  logic                               re,
	input  logic [$clog2(DEPTH)-1:0]           raddr,
	output logic [laq_pkg::DATA_W-1:0]         rdata
);
	import laq_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds until the next read so a stalled consumer can wait on it.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sim/linear_array_queue_core_test.sv
// Testbench for linear_array_queue_core: directed and random queue requests over the
// stream ports, with a built-in queue model that predicts every result.
// Depends on laq_pkg and the linear_array_queue_core RTL; reads no files.
module linear_array_queue_core_test;
	import laq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QDEPTH     = DEPTH_DEF;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned RANDOM_REQ = 135;

	// Receiver stall patterns.
	localparam int RX_ALWAYS = 0;
	localparam int RX_MOSTLY = 1;
	localparam int RX_THIRD  = 2;
	localparam int RX_SPARSE = 3;

	typedef struct packed {
		status_t     status;
		logic [31:0] data;
		logic        last;
	} queue_result_t;

	// Mirror of the queue: its own slots and indices, plus the results still owed.
	class queue_mirror;
		logic [31:0]   slot_mem [QDEPTH];
		int unsigned   front_idx;
		int unsigned   rear_idx;
		bit            empty_flag;
		queue_result_t owed_results[$];
		int unsigned   error_count;

		function new();
			front_idx   = 0;
			rear_idx    = 0;
			empty_flag  = 1'b1;
			error_count = 0;
		endfunction

		function bit at_last_slot();
			return !empty_flag && rear_idx >= QDEPTH - 1;
		endfunction

		function int unsigned owed_count();
			return owed_results.size();
		endfunction

		// Work out what an accepted request must produce and update the mirror.
		function void apply_request(func_t op, logic [31:0] value);
			queue_result_t r;
			r = '{ST_OK, 32'd0, 1'b1};
			if (op == FN_ENQ) begin
				if (empty_flag) begin
					front_idx   = 0;
					rear_idx    = 0;
					slot_mem[0] = value;
					empty_flag  = 1'b0;
				end else if (rear_idx >= QDEPTH - 1) begin
					// No wrap: refused even when front slots were freed.
					r.status = ST_FULL;
				end else begin
					rear_idx++;
					slot_mem[rear_idx] = value;
				end
				owed_results.push_back(r);
			end else if (empty_flag) begin
				r.status = ST_EMPTY;
				owed_results.push_back(r);
			end else begin
				case (op)
					FN_DEQ: begin
						r.data = slot_mem[front_idx];
						if (front_idx == rear_idx) begin
							front_idx  = 0;
							rear_idx   = 0;
							empty_flag = 1'b1;
						end else begin
							front_idx++;
						end
						owed_results.push_back(r);
					end
					FN_PEEK: begin
						r.data = slot_mem[front_idx];
						owed_results.push_back(r);
					end
					default: begin
						for (int unsigned i = front_idx; i <= rear_idx; i++) begin
							r.data = slot_mem[i];
							r.last = (i == rear_idx);
							owed_results.push_back(r);
						end
					end
				endcase
			end
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			error_count++;
		endtask

		task check_result(status_t st, logic [31:0] d, logic l);
			queue_result_t exp_r;
			if (owed_results.size() == 0) begin
				report($sformatf("unexpected result status %0d data %h last %b", st, d, l));
				return;
			end
			exp_r = owed_results.pop_front();
			if (st !== exp_r.status)
				report($sformatf("status %0d, wanted %0d", st, exp_r.status));
			if (d !== exp_r.data)
				report($sformatf("data %h, wanted %h", d, exp_r.data));
			if (l !== exp_r.last)
				report($sformatf("last %b, wanted %b", l, exp_r.last));
		endtask
	endclass

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [DATA_W-1:0]   s_tdata  = '0;
	logic [1:0]          s_tuser  = FN_ENQ;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	queue_mirror mirror = new();

	int unsigned burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	linear_array_queue_core #(.DEPTH(QDEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Present one request and hold it until the block takes it. Bursts of random
	// length are separated by random gaps, now and then a long burst with none.
	task automatic send_request(func_t op, logic [31:0] value);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 5);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 10);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		mirror.apply_request(op, value);
		burst_left--;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Random requests lean toward filling or draining; the lean flips at the
	// ends of the array and at random, which breaks up the clean sequences.
	task automatic run_random();
		bit          filling;
		int unsigned roll;
		func_t       op;
		filling = 1'b1;
		for (int n = 0; n < RANDOM_REQ; n++) begin
			if (mirror.at_last_slot() && $urandom_range(0, 2) != 0)
				filling = 1'b0;
			else if (mirror.empty_flag && $urandom_range(0, 2) != 0)
				filling = 1'b1;
			else if ($urandom_range(0, 11) == 0)
				filling = !filling;
			roll = $urandom_range(0, 99);
			if (filling)
				op = (roll < 70) ? FN_ENQ : (roll < 80) ? FN_DEQ : (roll < 90) ? FN_PEEK : FN_DISP;
			else
				op = (roll < 10) ? FN_ENQ : (roll < 70) ? FN_DEQ : (roll < 85) ? FN_PEEK : FN_DISP;
			send_request(op, pick_value());
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Everything but enqueue on an empty queue answers empty.
		send_request(FN_DISP, $urandom);
		send_request(FN_PEEK, $urandom);
		send_request(FN_DEQ, $urandom);
		// Fill every slot with extreme and alternating patterns.
		send_request(FN_ENQ, 32'h8000_0000);
		send_request(FN_ENQ, 32'h7FFF_FFFF);
		send_request(FN_ENQ, 32'h0000_0000);
		send_request(FN_ENQ, 32'hFFFF_FFFF);
		send_request(FN_ENQ, 32'h5555_5555);
		send_request(FN_ENQ, 32'hAAAA_AAAA);
		send_request(FN_ENQ, 32'h0000_0001);
		send_request(FN_ENQ, $urandom);
		// Full, then a display of all slots.
		send_request(FN_ENQ, $urandom);
		send_request(FN_DISP, $urandom);
		send_request(FN_PEEK, $urandom);
		send_request(FN_DEQ, $urandom);
		// The front slot is free now, but the array does not wrap.
		send_request(FN_ENQ, $urandom);
		send_request(FN_DISP, $urandom);
		// Drain to empty, which puts both indices back to zero.
		repeat (7) send_request(FN_DEQ, $urandom);
		send_request(FN_ENQ, 32'h1234_5678);

		run_random();
		s_tvalid <= 1'b0;

		while (mirror.owed_count() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mirror.error_count == 0) begin
			$display("linear_array_queue_core test passed");
		end else begin
			$display("linear_array_queue_core test failed");
		end
		$finish;
	end

	// Result side: check each accepted result, then pick the next ready value
	// from a stall pattern that is redrawn at random.
	int          rx_mode    = RX_ALWAYS;
	int unsigned rx_left    = 0;
	int unsigned rx_cycle   = 0;

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			mirror.check_result(m_tuser, m_tdata, m_tlast);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
			rx_left = $urandom_range(16, 80);
		end
		rx_left--;
		rx_cycle++;
		case (rx_mode)
			RX_ALWAYS: m_tready <= 1'b1;
			RX_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
			RX_THIRD:  m_tready <= (rx_cycle % 3 == 0);
			default:   m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// A run that stops moving on both sides ends here.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
			$display("linear_array_queue_core test failed");
			$finish;
		end
	end

endmodule
